>>> rtl/six_axis_admittance_step_core_assert.svh
// ----------------------------------------------------------------------------
// six axis admittance step assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef SIX_AXIS_ADMITTANCE_STEP_CORE_ASSERT_SVH
`define SIX_AXIS_ADMITTANCE_STEP_CORE_ASSERT_SVH

// antecedent in a cycle implies consequent in the next
`define SASC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sasc assertion failed");

// expression must never hold
`define SASC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("sasc assertion failed");

`endif

>>> rtl/sasc_pkg.sv
// ----------------------------------------------------------------------------
// sasc_pkg
// widths, register indexes, reset values and saturation for the admittance step
// ----------------------------------------------------------------------------
package sasc_pkg;

  localparam int VW       = 32;          // value width, signed q16.16
  localparam int MW       = VW + 1;      // multiplier operand width
  localparam int PW       = 2 * MW;      // full product width
  localparam int DTW      = 24;          // step time width, q0.24
  localparam int SQW      = 64;          // squared norm accumulator width
  localparam int NUM_POSE = 6;
  localparam int LIN_AXES = 3;
  localparam int AXES_DEF = 6;
  localparam int AXW      = $clog2(NUM_POSE);
  localparam int CFG_IW   = 8;
  localparam int FRAC_Q   = 16;
  localparam int FRAC_DT  = 24;

  localparam logic [CFG_IW-1:0] REG_STEP_TIME   = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_INV_MASS_L  = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_INV_MASS_A  = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_DAMPING_L   = CFG_IW'(3);
  localparam logic [CFG_IW-1:0] REG_DAMPING_A   = CFG_IW'(4);
  localparam logic [CFG_IW-1:0] REG_STIFFNESS_L = CFG_IW'(5);
  localparam logic [CFG_IW-1:0] REG_STIFFNESS_A = CFG_IW'(6);
  localparam logic [CFG_IW-1:0] REG_REACH       = CFG_IW'(7);

  localparam logic [DTW-1:0] RST_STEP_TIME   = DTW'(33554);
  localparam logic [VW-1:0]  RST_INV_MASS_L  = VW'(65536);
  localparam logic [VW-1:0]  RST_INV_MASS_A  = VW'(65536);
  localparam logic [VW-1:0]  RST_DAMPING_L   = VW'(655360);
  localparam logic [VW-1:0]  RST_DAMPING_A   = VW'(655360);
  localparam logic [VW-1:0]  RST_STIFFNESS_L = VW'(655360);
  localparam logic [VW-1:0]  RST_STIFFNESS_A = VW'(327680);
  localparam logic [VW-1:0]  RST_REACH       = VW'(47350);

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  // clamp a wide signed value to the signed value range
  function automatic logic signed [VW-1:0] sat_val(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = PW'(VAL_MAX);
    lo = PW'(VAL_MIN);
    if (x > hi) begin
      return VAL_MAX;
    end else if (x < lo) begin
      return VAL_MIN;
    end
    return x[VW-1:0];
  endfunction

endpackage

>>> rtl/six_axis_admittance_step_core.sv
// ----------------------------------------------------------------------------
// six_axis_admittance_step_core
// per-axis mass-spring-damper admittance step with semi-implicit integration
// ----------------------------------------------------------------------------
// axes are stepped in turn on the one shared 33x33 signed multiplier; active
// axes run damping, stiffness, net force, acceleration, velocity, position and
// pose steps, linear axes add a squared-norm step, inactive axes skip to pose.
// s_tready is high only while no item is in work; a finished item waits in the
// output register while the next one is taken.
// reset clears velocity and position offsets, loads register defaults and
// empties the output register.
module six_axis_admittance_step_core #(
  parameter int AXES = sasc_pkg::AXES_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // config write channel
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [sasc_pkg::CFG_IW-1:0]                cfg_index,
  input  logic [sasc_pkg::VW-1:0]                    cfg_data,
  // input items
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z,
  // ref_x, ref_y, ref_z, ref_roll, ref_pitch, ref_yaw
  input  logic [2*sasc_pkg::NUM_POSE*sasc_pkg::VW-1:0] s_tdata,
  // result items
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // pose_x, pose_y, pose_z, pose_roll, pose_pitch, pose_yaw
  output logic [sasc_pkg::NUM_POSE*sasc_pkg::VW-1:0] m_tdata,
  // out_of_reach
  output logic [0:0]                                 m_tuser
);
  import sasc_pkg::*;

  localparam int AIW = (AXES > 1) ? $clog2(AXES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [3:0] SP_DAMP    = 4'd0;
  localparam logic [3:0] SP_STIFF   = 4'd1;
  localparam logic [3:0] SP_NET     = 4'd2;
  localparam logic [3:0] SP_ACC_MUL = 4'd3;
  localparam logic [3:0] SP_ACC     = 4'd4;
  localparam logic [3:0] SP_VEL_MUL = 4'd5;
  localparam logic [3:0] SP_VEL     = 4'd6;
  localparam logic [3:0] SP_POS_MUL = 4'd7;
  localparam logic [3:0] SP_POS     = 4'd8;
  localparam logic [3:0] SP_POSE    = 4'd9;
  localparam logic [3:0] SP_SQ      = 4'd10;

  // configuration registers
  logic [DTW-1:0] step_time;
  logic [VW-1:0]  inv_mass_l, inv_mass_a, damping_l, damping_a;
  logic [VW-1:0]  stiffness_l, stiffness_a, reach_limit;

  // control
  logic [1:0]     state;
  logic [AXW-1:0] ax;
  logic [3:0]     stp;
  logic           sq_pend;

  // state and datapath
  logic signed [VW-1:0] vel [AXES];
  logic signed [VW-1:0] pos [AXES];
  logic signed [VW-1:0] force_r [NUM_POSE];
  logic signed [VW-1:0] ref_r [NUM_POSE];
  logic signed [VW-1:0] pose_w [NUM_POSE];
  logic signed [VW-1:0] t;
  logic signed [PW-1:0] prod;
  logic [SQW-1:0]       sumsq;

  logic                 accept, load_out, active, lin;
  logic [AIW-1:0]       ax_i;
  logic signed [VW-1:0] v_cur, p_cur, f_cur, ref_cur;
  logic signed [MW-1:0] ma, mb;
  logic signed [VW-1:0] q_sat, net_val, step_sum, pose_val;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign load_out  = (state == ST_DONE) && (!m_tvalid || m_tready);

  assign active  = int'(ax) < AXES;
  assign lin     = int'(ax) < LIN_AXES;
  assign ax_i    = ax[AIW-1:0];
  assign v_cur   = active ? vel[ax_i] : '0;
  assign p_cur   = active ? pos[ax_i] : '0;
  assign f_cur   = force_r[ax];
  assign ref_cur = ref_r[ax];

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (stp)
      SP_DAMP: begin
        ma = $signed({1'b0, lin ? damping_l : damping_a});
        mb = MW'(v_cur);
      end
      SP_STIFF: begin
        ma = $signed({1'b0, lin ? stiffness_l : stiffness_a});
        mb = MW'(p_cur);
      end
      SP_ACC_MUL: begin
        ma = $signed({1'b0, lin ? inv_mass_l : inv_mass_a});
        mb = MW'(t);
      end
      SP_VEL_MUL, SP_POS_MUL: begin
        ma = $signed(MW'(step_time));
        mb = MW'(t);
      end
      SP_SQ: begin
        ma = MW'(t);
        mb = MW'(t);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // product post-processing, floor shifts then clamp
  always_comb begin
    q_sat    = sat_val(prod >>> FRAC_Q);
    net_val  = sat_val(PW'(f_cur) - PW'(t) - PW'(q_sat));
    step_sum = sat_val(PW'((stp == SP_VEL) ? v_cur : p_cur) + (prod >>> FRAC_DT));
    pose_val = sat_val(PW'(ref_cur) + PW'(t));
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time   <= RST_STEP_TIME;
      inv_mass_l  <= RST_INV_MASS_L;
      inv_mass_a  <= RST_INV_MASS_A;
      damping_l   <= RST_DAMPING_L;
      damping_a   <= RST_DAMPING_A;
      stiffness_l <= RST_STIFFNESS_L;
      stiffness_a <= RST_STIFFNESS_A;
      reach_limit <= RST_REACH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_TIME:   step_time   <= cfg_data[DTW-1:0];
        REG_INV_MASS_L:  inv_mass_l  <= cfg_data;
        REG_INV_MASS_A:  inv_mass_a  <= cfg_data;
        REG_DAMPING_L:   damping_l   <= cfg_data;
        REG_DAMPING_A:   damping_a   <= cfg_data;
        REG_STIFFNESS_L: stiffness_l <= cfg_data;
        REG_STIFFNESS_A: stiffness_a <= cfg_data;
        REG_REACH:       reach_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and offset state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ax       <= '0;
      stp      <= SP_DAMP;
      sq_pend  <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        vel[i] <= '0;
        pos[i] <= '0;
      end
    end else begin
      sq_pend <= 1'b0;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            ax    <= '0;
            stp   <= SP_DAMP;
          end
        end
        ST_RUN: begin
          unique case (stp)
            SP_DAMP: begin
              stp <= active ? SP_STIFF : SP_POSE;
            end
            SP_VEL: begin
              vel[ax_i] <= step_sum;
              stp       <= SP_POS_MUL;
            end
            SP_POS: begin
              pos[ax_i] <= step_sum;
              stp       <= SP_POSE;
            end
            SP_POSE: begin
              if (lin) begin
                stp <= SP_SQ;
              end else if (int'(ax) == NUM_POSE - 1) begin
                state <= ST_DONE;
              end else begin
                ax  <= ax + AXW'(1);
                stp <= SP_DAMP;
              end
            end
            SP_SQ: begin
              sq_pend <= 1'b1;
              ax      <= ax + AXW'(1);
              stp     <= SP_DAMP;
            end
            default: begin
              stp <= stp + 4'd1;
            end
          endcase
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (accept) begin
      for (int i = 0; i < NUM_POSE; i++) begin
        force_r[i] <= s_tdata[i*VW +: VW];
        ref_r[i]   <= s_tdata[(NUM_POSE+i)*VW +: VW];
      end
      sumsq <= '0;
    end else if (sq_pend) begin
      // squares are never negative, low bits hold the full value
      sumsq <= sumsq + prod[SQW-1:0];
    end
    if (state == ST_RUN) begin
      unique case (stp)
        SP_DAMP:           if (!active) t <= '0;
        SP_STIFF, SP_ACC:  t <= q_sat;
        SP_NET:            t <= net_val;
        SP_VEL, SP_POS:    t <= step_sum;
        SP_POSE: begin
          t          <= pose_val;
          pose_w[ax] <= pose_val;
        end
        default: ;
      endcase
    end
    if (load_out) begin
      for (int i = 0; i < NUM_POSE; i++) begin
        m_tdata[i*VW +: VW] <= pose_w[i];
      end
      m_tuser[0] <= sumsq > (SQW'(reach_limit) << FRAC_Q);
    end
  end

`include "six_axis_admittance_step_core_assert.svh"

  `SASC_ASSERT_NEXT(a_accept_starts, accept, (state == ST_RUN) && (ax == '0) && (stp == SP_DAMP))
  `SASC_ASSERT_NEXT(a_done_loads, load_out, m_tvalid && (state == ST_IDLE))
  `SASC_ASSERT_NEVER(a_axis_range, int'(ax) >= NUM_POSE)
  `SASC_ASSERT_NEVER(a_square_lin, sq_pend && (int'(ax) > LIN_AXES))

endmodule
